[design/pdte_pkg.sv]
// Shared types and constants for the PDF date to epoch seconds converter.
package pdte_pkg;

  typedef enum logic [2:0] {
    PH_D      = 3'd0,
    PH_COLON  = 3'd1,
    PH_DIGITS = 3'd2,
    PH_PLUS   = 3'd3,
    PH_MINUS  = 3'd4,
    PH_QUOTE  = 3'd5,
    PH_END    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_NORM  = 3'd1,
    BK_ERA   = 3'd2,
    BK_DAYS  = 3'd3,
    BK_SUM   = 3'd4,
    BK_MUL   = 3'd5,
    BK_TOTAL = 3'd6,
    BK_OUT   = 3'd7
  } bk_state_t;

  // Parsed date handed from the front end to the back end.
  typedef struct packed {
    logic               ok;
    logic [13:0]        year;
    logic [6:0]         mon_p;    // month number, 0 means December of the year before
    logic [6:0]         mday;
    logic [6:0]         hour;
    logic [6:0]         minute;
    logic [6:0]         second;
    logic signed [19:0] zone;
  } date_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [4:0] POS_MAX     = 5'd31;
  localparam logic [4:0] POS_ZONE_H1 = 5'd17;
  localparam logic [4:0] POS_ZONE_H0 = 5'd18;
  localparam logic [4:0] POS_ZONE_Q  = 5'd19;
  localparam logic [4:0] POS_ZONE_M1 = 5'd20;
  localparam logic [4:0] POS_ZONE_M0 = 5'd21;
  localparam logic [4:0] DIGITS_FULL = 5'd14;

  localparam logic [15:0] ZW_H1 = 16'd36000;
  localparam logic [15:0] ZW_H0 = 16'd3600;
  localparam logic [15:0] ZW_M1 = 16'd600;
  localparam logic [15:0] ZW_M0 = 16'd60;

  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
  localparam logic [19:0] DAY_BIAS     = 20'd865566;
  localparam logic [13:0] YEAR_BIAS    = 14'd399;
  localparam logic [8:0]  ERA_YEARS    = 9'd400;

endpackage

[design/pdf_date_to_epoch_seconds.sv]
// Top level of the PDF date string to UTC epoch seconds converter.
//
// Characters of a "D:YYYY[MM[DD[hh[mm[ss[Z|+HH'mm['] | -HH'mm[']]]]]]]" string
// are taken one per cycle; the parser holds no stall of its own and only waits
// when the result queue (QUEUE_DEPTH entries) is full. The character flagged
// with in_last_char yields one result: out_is_date and the UTC seconds since
// 1970-01-01 in out_epoch_seconds (zero when the string is not a date). Each
// conversion in the back end walks the normalization, era loop (one pass per
// 400-year era of the year, up to 26), day count, sum, multiply and total
// states; a rejected string goes straight to output. A finished result sits
// in the output register while the next one is converted. Reset is synchronous.
module pdf_date_to_epoch_seconds #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_date,
  output logic signed [38:0] out_epoch_seconds
);

  pdte_pkg::q_stat_t   q_stat;
  pdte_pkg::date_rec_t push_rec;
  pdte_pkg::date_rec_t pop_rec;
  logic                push;
  logic                pop;

  pdte_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .q_stat       (q_stat),
    .push         (push),
    .push_rec     (push_rec)
  );

  pdte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .q_stat   (q_stat)
  );

  pdte_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .pop_rec           (pop_rec),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_date       (out_is_date),
    .out_epoch_seconds (out_epoch_seconds)
  );

endmodule

[design/pdte_front.sv]
// Front end: character parser that collects date fields and zone offset.
module pdte_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char_code,
  input  logic                in_last_char,
  input  pdte_pkg::q_stat_t   q_stat,
  output logic                push,
  output pdte_pkg::date_rec_t push_rec
);

  pdte_pkg::phase_t   phase_r, phase_nxt;
  logic [4:0]         pos_r, pos_nxt;
  logic [4:0]         dc_r, dc_nxt;
  logic [13:0]        year_r, year_nxt;
  logic [6:0]         month_r, month_nxt;
  logic [6:0]         day_r, day_nxt;
  logic [6:0]         hour_r, hour_nxt;
  logic [6:0]         min_r, min_nxt;
  logic [6:0]         sec_r, sec_nxt;
  logic signed [19:0] zone_r, zone_nxt;
  logic               rej_r, rej_nxt;

  logic               acc;
  logic               is_dig;
  logic [3:0]         dig;
  logic [7:0]         dsub;
  logic [15:0]        zw;
  logic signed [19:0] zprod;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;
  assign is_dig   = (in_char_code >= pdte_pkg::CH_ZERO) && (in_char_code <= pdte_pkg::CH_NINE);
  assign dsub     = in_char_code - pdte_pkg::CH_ZERO;
  assign dig      = dsub[3:0];

  always_comb begin
    case (pos_r)
      pdte_pkg::POS_ZONE_H1: zw = pdte_pkg::ZW_H1;
      pdte_pkg::POS_ZONE_H0: zw = pdte_pkg::ZW_H0;
      pdte_pkg::POS_ZONE_M1: zw = pdte_pkg::ZW_M1;
      pdte_pkg::POS_ZONE_M0: zw = pdte_pkg::ZW_M0;
      default:               zw = 16'd0;
    endcase
  end

  assign zprod = $signed({16'd0, dig}) * $signed({4'd0, zw});

  always_comb begin
    phase_nxt = phase_r;
    dc_nxt    = dc_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    zone_nxt  = zone_r;
    rej_nxt   = rej_r;
    pos_nxt   = (pos_r == pdte_pkg::POS_MAX) ? pos_r : pos_r + 5'd1;
    if (!rej_r) begin
      case (phase_r)
        pdte_pkg::PH_D: begin
          if (in_char_code == pdte_pkg::CH_D) phase_nxt = pdte_pkg::PH_COLON;
          else rej_nxt = 1'b1;
        end
        pdte_pkg::PH_COLON: begin
          if (in_char_code == pdte_pkg::CH_COLON) phase_nxt = pdte_pkg::PH_DIGITS;
          else rej_nxt = 1'b1;
        end
        pdte_pkg::PH_DIGITS: begin
          if (is_dig) begin
            if (dc_r < pdte_pkg::DIGITS_FULL) begin
              dc_nxt = dc_r + 5'd1;
              if (dc_r < 5'd4)       year_nxt  = 14'(year_r * 14'd10 + 14'(dig));
              else if (dc_r < 5'd6)  month_nxt = 7'(month_r * 7'd10 + 7'(dig));
              else if (dc_r < 5'd8)  day_nxt   = 7'(day_r * 7'd10 + 7'(dig));
              else if (dc_r < 5'd10) hour_nxt  = 7'(hour_r * 7'd10 + 7'(dig));
              else if (dc_r < 5'd12) min_nxt   = 7'(min_r * 7'd10 + 7'(dig));
              else                   sec_nxt   = 7'(sec_r * 7'd10 + 7'(dig));
            end else begin
              rej_nxt = 1'b1;
            end
          end else if (dc_r != pdte_pkg::DIGITS_FULL) begin
            rej_nxt = 1'b1;
          end else if (in_char_code == pdte_pkg::CH_Z) begin
            phase_nxt = pdte_pkg::PH_END;
          end else if (in_char_code == pdte_pkg::CH_PLUS) begin
            phase_nxt = pdte_pkg::PH_PLUS;
          end else if (in_char_code == pdte_pkg::CH_MINUS) begin
            phase_nxt = pdte_pkg::PH_MINUS;
          end else begin
            rej_nxt = 1'b1;
          end
        end
        pdte_pkg::PH_PLUS, pdte_pkg::PH_MINUS: begin
          if (pos_r == pdte_pkg::POS_ZONE_Q) begin
            if (in_char_code != pdte_pkg::CH_QUOTE) rej_nxt = 1'b1;
          end else if (!is_dig || zw == 16'd0) begin
            rej_nxt = 1'b1;
          end else begin
            if (phase_r == pdte_pkg::PH_MINUS) zone_nxt = zone_r - zprod;
            else zone_nxt = zone_r + zprod;
            if (pos_r == pdte_pkg::POS_ZONE_M0) phase_nxt = pdte_pkg::PH_QUOTE;
          end
        end
        pdte_pkg::PH_QUOTE: begin
          if (in_char_code == pdte_pkg::CH_QUOTE) phase_nxt = pdte_pkg::PH_END;
          else rej_nxt = 1'b1;
        end
        default: rej_nxt = 1'b1;
      endcase
    end
  end

  assign push = acc && in_last_char;

  always_comb begin
    push_rec.ok = !rej_nxt &&
                  (((phase_nxt == pdte_pkg::PH_DIGITS) && (dc_nxt >= 5'd4) && !dc_nxt[0]) ||
                   (phase_nxt == pdte_pkg::PH_QUOTE) || (phase_nxt == pdte_pkg::PH_END));
    push_rec.year   = year_nxt;
    push_rec.mon_p  = (dc_nxt >= 5'd6) ? month_nxt : 7'd1;
    push_rec.mday   = (dc_nxt >= 5'd8) ? day_nxt : 7'd1;
    push_rec.hour   = hour_nxt;
    push_rec.minute = min_nxt;
    push_rec.second = sec_nxt;
    push_rec.zone   = zone_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      phase_r <= pdte_pkg::PH_D;
      pos_r   <= 5'd0;
      dc_r    <= 5'd0;
      year_r  <= 14'd0;
      month_r <= 7'd0;
      day_r   <= 7'd0;
      hour_r  <= 7'd0;
      min_r   <= 7'd0;
      sec_r   <= 7'd0;
      zone_r  <= 20'sd0;
      rej_r   <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      dc_r    <= dc_nxt;
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
      hour_r  <= hour_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      zone_r  <= zone_nxt;
      rej_r   <= rej_nxt;
    end
  end

endmodule

[design/pdte_queue.sv]
// Queue of parsed dates between the parser and the calendar back end.
module pdte_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pdte_pkg::date_rec_t push_rec,
  input  logic                pop,
  output pdte_pkg::date_rec_t pop_rec,
  output pdte_pkg::q_stat_t   q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  pdte_pkg::date_rec_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_rec      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

[design/pdte_back.sv]
// Back end: calendar conversion sequencer and output register.
module pdte_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pdte_pkg::q_stat_t   q_stat,
  input  pdte_pkg::date_rec_t pop_rec,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_is_date,
  output logic signed [38:0]  out_epoch_seconds
);

  pdte_pkg::bk_state_t state_r, state_nxt;

  pdte_pkg::date_rec_t rec_r;
  logic [13:0]         yy_r;
  logic [4:0]          era_r;
  logic [8:0]          doy_r;
  logic [18:0]         hms_r;
  logic [21:0]         era_days_r;
  logic [17:0]         doe_r;
  logic signed [23:0]  days_r;
  logic signed [40:0]  dsec_r;
  logic signed [40:0]  t_r;

  logic                out_valid_r;
  logic                out_is_date_r;
  logic signed [38:0]  out_epoch_r;

  logic                out_load;
  logic                out_free;

  logic [6:0]          mon;
  logic [3:0]          cnt12;
  logic [3:0]          qp;
  logic [3:0]          mm;
  logic [14:0]         yy_sum;
  logic [8:0]          yoe;
  logic [1:0]          cent;
  logic signed [40:0]  t_final;
  logic                date_ok;

  function automatic logic [8:0] month_doy(input logic [3:0] m);
    case (m)
      4'd0:    month_doy = 9'd306;
      4'd1:    month_doy = 9'd337;
      4'd2:    month_doy = 9'd0;
      4'd3:    month_doy = 9'd31;
      4'd4:    month_doy = 9'd61;
      4'd5:    month_doy = 9'd92;
      4'd6:    month_doy = 9'd122;
      4'd7:    month_doy = 9'd153;
      4'd8:    month_doy = 9'd184;
      4'd9:    month_doy = 9'd214;
      4'd10:   month_doy = 9'd245;
      4'd11:   month_doy = 9'd275;
      default: month_doy = 9'd0;
    endcase
  endfunction

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pdte_pkg::BK_IDLE: begin
        if (!q_stat.empty) state_nxt = pop_rec.ok ? pdte_pkg::BK_NORM : pdte_pkg::BK_OUT;
      end
      pdte_pkg::BK_NORM:  state_nxt = pdte_pkg::BK_ERA;
      pdte_pkg::BK_ERA: begin
        if (yy_r < 14'(pdte_pkg::ERA_YEARS)) state_nxt = pdte_pkg::BK_DAYS;
      end
      pdte_pkg::BK_DAYS:  state_nxt = pdte_pkg::BK_SUM;
      pdte_pkg::BK_SUM:   state_nxt = pdte_pkg::BK_MUL;
      pdte_pkg::BK_MUL:   state_nxt = pdte_pkg::BK_TOTAL;
      pdte_pkg::BK_TOTAL: state_nxt = pdte_pkg::BK_OUT;
      pdte_pkg::BK_OUT: begin
        if (out_free) state_nxt = pdte_pkg::BK_IDLE;
      end
      default: state_nxt = pdte_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (state_r)
      pdte_pkg::BK_IDLE: pop = !q_stat.empty;
      pdte_pkg::BK_OUT:  out_load = out_free;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pdte_pkg::BK_IDLE;
    else state_r <= state_nxt;
  end

  // month normalization into year carry and month index
  always_comb begin
    mon   = rec_r.mon_p - 7'd1;
    cnt12 = 4'd0;
    for (int i = 1; i <= 8; i++) begin
      if (mon >= 7'(12 * i)) cnt12 = cnt12 + 4'd1;
    end
    if (rec_r.mon_p == 7'd0) begin
      qp = 4'd0;
      mm = 4'd11;
    end else begin
      qp = cnt12 + 4'd1;
      mm = 4'(mon - 7'(cnt12) * 7'd12);
    end
    yy_sum = {1'b0, rec_r.year} + {1'b0, pdte_pkg::YEAR_BIAS} + 15'(qp) -
             ((mm <= 4'd1) ? 15'd1 : 15'd0);
  end

  assign yoe  = yy_r[8:0];
  assign cent = {1'b0, (yoe >= 9'd100)} + {1'b0, (yoe >= 9'd200)} + {1'b0, (yoe >= 9'd300)};

  assign t_final = t_r - 41'(rec_r.zone);
  assign date_ok = rec_r.ok && (t_r > 41'sd0);

  always_ff @(posedge clk) begin
    case (state_r)
      pdte_pkg::BK_IDLE: rec_r <= pop_rec;
      pdte_pkg::BK_NORM: begin
        yy_r  <= yy_sum[13:0];
        era_r <= 5'd0;
        doy_r <= month_doy(mm);
        hms_r <= 19'(rec_r.hour * 19'd3600) + 19'(rec_r.minute * 19'd60) + 19'(rec_r.second);
      end
      pdte_pkg::BK_ERA: begin
        if (yy_r >= 14'(pdte_pkg::ERA_YEARS)) begin
          yy_r  <= yy_r - 14'(pdte_pkg::ERA_YEARS);
          era_r <= era_r + 5'd1;
        end
      end
      pdte_pkg::BK_DAYS: begin
        doe_r      <= 18'(yoe * 18'd365) + 18'(yoe >> 2) - 18'(cent) + 18'(doy_r);
        era_days_r <= 22'(era_r) * 22'(pdte_pkg::DAYS_PER_ERA);
      end
      pdte_pkg::BK_SUM: begin
        days_r <= $signed({2'b0, era_days_r}) + $signed({6'b0, doe_r}) +
                  $signed({17'b0, rec_r.mday}) - $signed({4'b0, pdte_pkg::DAY_BIAS});
      end
      pdte_pkg::BK_MUL:   dsec_r <= 41'(days_r) * 41'sd86400;
      pdte_pkg::BK_TOTAL: t_r <= dsec_r + $signed({22'b0, hms_r});
      default: begin
        yy_r <= yy_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_is_date_r <= date_ok;
      out_epoch_r   <= date_ok ? t_final[38:0] : 39'sd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_date       = out_is_date_r;
  assign out_epoch_seconds = out_epoch_r;

endmodule
